FILE: rtl/core/quaternion_slerp_macros.svh
// assertion macros for the quaternion slerp checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef QUATERNION_SLERP_MACROS_SVH
`define QUATERNION_SLERP_MACROS_SVH

// implication checked while out of reset
`define QSLP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define QSLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/qslp_pkg.sv
// shared types, formats and constants of the quaternion slerp pipeline
// no dependencies
`default_nettype none

package qslp_pkg;

    localparam int CB    = 24;           // component width, signed Q2.FB
    localparam int FB    = CB - 2;       // fraction bits of the components
    localparam int CF    = 30;           // fraction bits inside the cordic units
    localparam int NSTEP = 30;           // cordic steps
    localparam int XW    = CF + 4;       // cordic x/y width, signed
    localparam int ZW    = CF + 3;       // cordic angle accumulator, signed
    localparam int AW    = CF + 2;       // clamped angle, unsigned
    localparam int SW    = CF + 2;       // clamped sine, unsigned
    localparam int NW    = 2 * CF + 2;   // square root working width
    localparam int SQSTEPS = CF + 1;     // square root steps, one result bit each

    localparam logic [FB:0] UNIT = {1'b1, {FB{1'b0}}};
    localparam logic [XW-1:0] INV_GAIN = XW'(652032874);
    localparam logic [CB-2:0] THR_RESET = (CB-1)'(2**FB - (2**FB + 5000) / 10000);

    // front 3, sqrt, acos and scale, sine, divider, blend 3
    localparam int LAT = 3 + SQSTEPS + (NSTEP + 1) + NSTEP + (FB + 1) + 3;

    // atan(2^-i) in Q.30, truncated
    localparam logic [AW-1:0] ATAN_TAB [NSTEP] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
        32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
        32'd31, 32'd15, 32'd7, 32'd3, 32'd1
    };

    typedef logic signed [CB-1:0] t_comp;
    typedef logic [CB-2:0]        t_frac;

    typedef struct packed {
        t_comp first_w;
        t_comp first_x;
        t_comp first_y;
        t_comp first_z;
        t_comp second_w;
        t_comp second_x;
        t_comp second_y;
        t_comp second_z;
        t_frac fraction;
    } t_in;

    typedef struct packed {
        t_comp out_w;
        t_comp out_x;
        t_comp out_y;
        t_comp out_z;
        logic  used_linear;
    } t_out;

    // data that rides along the pipeline with each word
    typedef struct packed {
        logic [3:0][CB-1:0] qa;   // first quaternion, index 0 is w
        logic [3:0][CB:0]   qb;   // second quaternion, flipped when the dot is negative
        logic [FB:0]        t;    // clamped fraction
        logic               lin;  // linear blend taken
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/core/qslp_front.sv
// front end: dot product, hemisphere flip, path choice and sqrt operand
// depends on qslp_pkg
`default_nettype none

module qslp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  qslp_pkg::t_in      i_word,
    input  qslp_pkg::t_frac    i_thr,
    output logic               o_vld,
    output qslp_pkg::t_side    o_side,
    output logic [2*qslp_pkg::CF:0] o_rest,
    output logic [qslp_pkg::CF:0]   o_d30
);
    import qslp_pkg::*;

    localparam int PW  = 2 * CB + 2;
    localparam int DTW = PW - FB;

    logic [2:0] r_vld;

    // stage 1: component products and clamped fraction
    logic [3:0][CB-1:0]          n1_qa, n1_qb;
    logic [FB:0]                 n1_t;
    logic signed [2*CB-1:0]      r1_p [4];
    logic [3:0][CB-1:0]          r1_qa, r1_qb;
    logic [FB:0]                 r1_t;

    assign n1_qa = {i_word.first_z, i_word.first_y, i_word.first_x, i_word.first_w};
    assign n1_qb = {i_word.second_z, i_word.second_y, i_word.second_x, i_word.second_w};
    assign n1_t  = (i_word.fraction > UNIT) ? UNIT : i_word.fraction;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r1_p[k] <= $signed(n1_qa[k]) * $signed(n1_qb[k]);
        end
        r1_qa <= n1_qa;
        r1_qb <= n1_qb;
        r1_t  <= n1_t;
    end

    // stage 2: floored dot, magnitude, flip and threshold compare
    logic signed [PW-1:0]  n2_sum;
    logic signed [DTW-1:0] n2_dot;
    logic                  n2_neg;
    logic [DTW-1:0]        n2_mag;
    logic [FB:0]           n2_d;
    t_side                 n2_side;
    t_side                 r2_side;
    logic [CF:0]           r2_d30;

    always_comb begin
        n2_sum = '0;
        for (int k = 0; k < 4; k++) begin
            n2_sum = n2_sum + PW'(r1_p[k]);
        end
        n2_dot = $signed(n2_sum[PW-1:FB]);
        n2_neg = n2_dot[DTW-1];
        n2_mag = n2_neg ? -n2_dot : n2_dot;
        n2_d   = (n2_mag > DTW'(UNIT)) ? UNIT : n2_mag[FB:0];
        n2_side.qa  = r1_qa;
        n2_side.t   = r1_t;
        n2_side.lin = (n2_mag >= DTW'(i_thr));
        for (int k = 0; k < 4; k++) begin
            n2_side.qb[k] = n2_neg ? -$signed({r1_qb[k][CB-1], r1_qb[k]})
                                   : $signed({r1_qb[k][CB-1], r1_qb[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        r2_side <= n2_side;
        r2_d30  <= {n2_d, {(CF-FB){1'b0}}};
    end

    // stage 3: one minus the squared dot
    logic [2*CF+1:0] n3_sq;
    t_side           r3_side;
    logic [2*CF:0]   r3_rest;
    logic [CF:0]     r3_d30;

    assign n3_sq = r2_d30 * r2_d30;

    always_ff @(posedge i_clk) begin
        r3_side <= r2_side;
        r3_rest <= {1'b1, {(2*CF){1'b0}}} - n3_sq[2*CF:0];
        r3_d30  <= r2_d30;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld  = r_vld[2];
    assign o_side = r3_side;
    assign o_rest = r3_rest;
    assign o_d30  = r3_d30;

endmodule

`default_nettype wire

FILE: rtl/core/qslp_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qslp_pkg
`default_nettype none

module qslp_isqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  qslp_pkg::t_side         i_side,
    input  logic [2*qslp_pkg::CF:0] i_rest,
    input  logic [qslp_pkg::CF:0]   i_d30,
    output logic                    o_vld,
    output qslp_pkg::t_side         o_side,
    output logic [qslp_pkg::CF:0]   o_s30,
    output logic [qslp_pkg::CF:0]   o_d30
);
    import qslp_pkg::*;

    logic [SQSTEPS-1:0] r_vld;
    logic [NW-1:0]      r_n   [SQSTEPS];
    logic [NW-1:0]      r_res [SQSTEPS];
    logic [CF:0]        r_d30 [SQSTEPS];
    t_side              r_side [SQSTEPS];

    for (genvar g = 0; g < SQSTEPS; g++) begin : g_step
        localparam logic [NW-1:0] BITV = NW'(1) << (2 * (CF - g));
        logic [NW-1:0] n_cur, res_cur, tryv, n_n, n_res;
        logic [CF:0]   d_cur;
        t_side         side_cur;

        if (g == 0) begin : g_first
            assign n_cur    = NW'(i_rest);
            assign res_cur  = '0;
            assign d_cur    = i_d30;
            assign side_cur = i_side;
        end else begin : g_next
            assign n_cur    = r_n[g-1];
            assign res_cur  = r_res[g-1];
            assign d_cur    = r_d30[g-1];
            assign side_cur = r_side[g-1];
        end

        // try to set this result bit
        always_comb begin
            tryv = res_cur + BITV;
            if (n_cur >= tryv) begin
                n_n   = n_cur - tryv;
                n_res = (res_cur >> 1) + BITV;
            end else begin
                n_n   = n_cur;
                n_res = res_cur >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[g]    <= n_n;
            r_res[g]  <= n_res;
            r_d30[g]  <= d_cur;
            r_side[g] <= side_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQSTEPS-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[SQSTEPS-1];
    assign o_side = r_side[SQSTEPS-1];
    assign o_s30  = r_res[SQSTEPS-1][CF:0];
    assign o_d30  = r_d30[SQSTEPS-1];

endmodule

`default_nettype wire

FILE: rtl/core/qslp_acos.sv
// vectoring cordic for the arc cosine, then the two scaled angles
// depends on qslp_pkg
`default_nettype none

module qslp_acos (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  qslp_pkg::t_side       i_side,
    input  logic [qslp_pkg::CF:0] i_d30,
    input  logic [qslp_pkg::CF:0] i_s30,
    output logic                  o_vld,
    output qslp_pkg::t_side       o_side,
    output logic [2:0][qslp_pkg::AW-1:0] o_ang
);
    import qslp_pkg::*;

    localparam int PAW = AW + FB + 1;

    logic [NSTEP:0]        r_vld;
    logic signed [XW-1:0]  r_x [NSTEP];
    logic signed [XW-1:0]  r_y [NSTEP];
    logic signed [ZW-1:0]  r_z [NSTEP];
    t_side                 r_side [NSTEP];

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        localparam logic signed [ZW-1:0] AT = $signed({{(ZW-AW){1'b0}}, ATAN_TAB[g]});
        logic signed [XW-1:0] x_cur, y_cur, dx, dy, n_x, n_y;
        logic signed [ZW-1:0] z_cur, n_z;
        t_side                side_cur;

        if (g == 0) begin : g_first
            assign x_cur    = $signed({{(XW-CF-1){1'b0}}, i_d30});
            assign y_cur    = $signed({{(XW-CF-1){1'b0}}, i_s30});
            assign z_cur    = '0;
            assign side_cur = i_side;
        end else begin : g_next
            assign x_cur    = r_x[g-1];
            assign y_cur    = r_y[g-1];
            assign z_cur    = r_z[g-1];
            assign side_cur = r_side[g-1];
        end

        // drive y toward zero
        always_comb begin
            dx = y_cur >>> g;
            dy = x_cur >>> g;
            if (y_cur > 0) begin
                n_x = x_cur + dx;
                n_y = y_cur - dy;
                n_z = z_cur + AT;
            end else begin
                n_x = x_cur - dx;
                n_y = y_cur + dy;
                n_z = z_cur - AT;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g]    <= n_x;
            r_y[g]    <= n_y;
            r_z[g]    <= n_z;
            r_side[g] <= side_cur;
        end
    end

    // scale stage: clamp the angle at zero, multiply by 1-t and t
    logic signed [ZW-1:0] ang_raw;
    logic [AW-1:0]        ang_c;
    logic [AW-1:0]        r_ang;
    logic [PAW-1:0]       r_pa, r_pb;
    t_side                r_side_s;

    assign ang_raw = r_z[NSTEP-1];
    assign ang_c   = ang_raw[ZW-1] ? '0 : ang_raw[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_ang    <= ang_c;
        r_pa     <= ang_c * (UNIT - r_side[NSTEP-1].t);
        r_pb     <= ang_c * r_side[NSTEP-1].t;
        r_side_s <= r_side[NSTEP-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTEP-1:0], i_vld};
        end
    end

    assign o_vld    = r_vld[NSTEP];
    assign o_side   = r_side_s;
    assign o_ang[0] = r_ang;
    assign o_ang[1] = r_pa[AW+FB-1:FB];
    assign o_ang[2] = r_pb[AW+FB-1:FB];

endmodule

`default_nettype wire

FILE: rtl/core/qslp_sin.sv
// three-lane rotation cordic: sine of the full and the two scaled angles
// depends on qslp_pkg
`default_nettype none

module qslp_sin (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  qslp_pkg::t_side              i_side,
    input  logic [2:0][qslp_pkg::AW-1:0] i_ang,
    output logic                         o_vld,
    output qslp_pkg::t_side              o_side,
    output logic [2:0][qslp_pkg::SW-1:0] o_sin
);
    import qslp_pkg::*;

    logic [NSTEP-1:0]     r_vld;
    logic signed [XW-1:0] r_x [3][NSTEP];
    logic signed [XW-1:0] r_y [3][NSTEP];
    logic signed [ZW-1:0] r_z [3][NSTEP];
    t_side                r_side [NSTEP];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        for (genvar g = 0; g < NSTEP; g++) begin : g_step
            localparam logic signed [ZW-1:0] AT =
                $signed({{(ZW-AW){1'b0}}, ATAN_TAB[g]});
            logic signed [XW-1:0] x_cur, y_cur, dx, dy, n_x, n_y;
            logic signed [ZW-1:0] z_cur, n_z;

            if (g == 0) begin : g_first
                assign x_cur = $signed(INV_GAIN);
                assign y_cur = '0;
                assign z_cur = $signed({{(ZW-AW){1'b0}}, i_ang[l]});
            end else begin : g_next
                assign x_cur = r_x[l][g-1];
                assign y_cur = r_y[l][g-1];
                assign z_cur = r_z[l][g-1];
            end

            // drive the residual angle toward zero
            always_comb begin
                dx = y_cur >>> g;
                dy = x_cur >>> g;
                if (z_cur >= 0) begin
                    n_x = x_cur - dx;
                    n_y = y_cur + dy;
                    n_z = z_cur - AT;
                end else begin
                    n_x = x_cur + dx;
                    n_y = y_cur - dy;
                    n_z = z_cur + AT;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[l][g] <= n_x;
                r_y[l][g] <= n_y;
                r_z[l][g] <= n_z;
            end
        end

        // negative sine reads as zero
        assign o_sin[l] = r_y[l][NSTEP-1][XW-1] ? '0 : r_y[l][NSTEP-1][SW-1:0];
    end

    // side data follows the lanes
    for (genvar g = 0; g < NSTEP; g++) begin : g_side
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_side[g] <= i_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_side[g] <= r_side[g-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTEP-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[NSTEP-1];
    assign o_side = r_side[NSTEP-1];

endmodule

`default_nettype wire

FILE: rtl/core/qslp_div.sv
// two-lane restoring divider for the slerp weights, one quotient bit per stage
// depends on qslp_pkg
`default_nettype none

module qslp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  qslp_pkg::t_side              i_side,
    input  logic [1:0][qslp_pkg::SW-1:0] i_part,
    input  logic [qslp_pkg::SW-1:0]      i_whole,
    output logic                         o_vld,
    output qslp_pkg::t_side              o_side,
    output logic [1:0][qslp_pkg::FB:0]   o_wt
);
    import qslp_pkg::*;

    localparam int NS = FB + 1;

    logic [NS-1:0]  r_vld;
    logic [SW:0]    r_rem   [2][NS];
    logic [FB-1:0]  r_q     [2][NS];
    logic           r_sat   [2][NS];
    logic [SW-1:0]  r_whole [NS];
    t_side          r_side  [NS];

    // stage 0: a zero sine forces the linear blend
    t_side n0_side;

    always_comb begin
        n0_side     = i_side;
        n0_side.lin = i_side.lin | (i_whole == '0);
    end

    always_ff @(posedge i_clk) begin
        r_whole[0] <= i_whole;
        r_side[0]  <= n0_side;
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        // part at or above whole gives a weight of one
        always_ff @(posedge i_clk) begin
            r_sat[l][0] <= (i_part[l] >= i_whole);
            r_rem[l][0] <= {1'b0, i_part[l]};
            r_q[l][0]   <= '0;
        end

        for (genvar s = 1; s < NS; s++) begin : g_step
            logic [SW:0]   two;
            logic [SW:0]   n_rem;
            logic [FB-1:0] n_q;

            always_comb begin
                two = {r_rem[l][s-1][SW-1:0], 1'b0};
                if (two >= {1'b0, r_whole[s-1]}) begin
                    n_rem = two - {1'b0, r_whole[s-1]};
                    n_q   = {r_q[l][s-1][FB-2:0], 1'b1};
                end else begin
                    n_rem = two;
                    n_q   = {r_q[l][s-1][FB-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[l][s] <= n_rem;
                r_q[l][s]   <= n_q;
                r_sat[l][s] <= r_sat[l][s-1];
            end
        end

        assign o_wt[l] = r_sat[l][NS-1] ? UNIT : {1'b0, r_q[l][NS-1]};
    end

    for (genvar s = 1; s < NS; s++) begin : g_carry
        always_ff @(posedge i_clk) begin
            r_whole[s] <= r_whole[s-1];
            r_side[s]  <= r_side[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];

endmodule

`default_nettype wire

FILE: rtl/core/qslp_blend.sv
// weighted sum of the two quaternions with rounding and saturation
// depends on qslp_pkg
`default_nettype none

module qslp_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  qslp_pkg::t_side      i_side,
    input  logic [qslp_pkg::FB:0] i_wa,
    input  logic [qslp_pkg::FB:0] i_wb,
    output logic                 o_vld,
    output qslp_pkg::t_out       o_word
);
    import qslp_pkg::*;

    localparam int PAW = CB + FB + 2;
    localparam int PBW = CB + FB + 3;
    localparam int ACW = CB + FB + 4;
    localparam int SHW = ACW - FB;
    localparam logic signed [SHW-1:0] HI = SHW'(2**(CB-1) - 1);
    localparam logic signed [SHW-1:0] LO = SHW'(-(2**(CB-1)));

    logic [2:0] r_vld;

    // stage 1: pick the weights of the chosen path
    logic [FB:0] r1_wa, r1_wb;
    t_side       r1_side;

    always_ff @(posedge i_clk) begin
        r1_wa   <= i_side.lin ? (UNIT - i_side.t) : i_wa;
        r1_wb   <= i_side.lin ? i_side.t : i_wb;
        r1_side <= i_side;
    end

    // stage 2: component products
    logic signed [PAW-1:0] r2_pa [4];
    logic signed [PBW-1:0] r2_pb [4];
    logic                  r2_lin;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r2_pa[k] <= $signed(r1_side.qa[k]) * $signed({1'b0, r1_wa});
            r2_pb[k] <= $signed(r1_side.qb[k]) * $signed({1'b0, r1_wb});
        end
        r2_lin <= r1_side.lin;
    end

    // stage 3: sum, round half up, saturate
    logic signed [ACW-1:0] n3_acc [4];
    logic signed [SHW-1:0] n3_sh  [4];
    logic [3:0][CB-1:0]    n3_r;
    t_out                  r3_word;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n3_acc[k] = ACW'(r2_pa[k]) + ACW'(r2_pb[k]) + ACW'(2**(FB-1));
            n3_sh[k]  = $signed(n3_acc[k][ACW-1:FB]);
            if (n3_sh[k] > HI) begin
                n3_r[k] = HI[CB-1:0];
            end else if (n3_sh[k] < LO) begin
                n3_r[k] = LO[CB-1:0];
            end else begin
                n3_r[k] = n3_sh[k][CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_word.out_w       <= n3_r[0];
        r3_word.out_x       <= n3_r[1];
        r3_word.out_y       <= n3_r[2];
        r3_word.out_z       <= n3_r[3];
        r3_word.used_linear <= r2_lin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld  = r_vld[2];
    assign o_word = r3_word;

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_slerp.sv
// quaternion slerp top level: threshold register and the pipeline chain
// depends on qslp_pkg and the qslp_* stage modules
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  input    | i_start, o_busy, i_word    | taken when i_start and !o_busy
//  result   | o_strobe, o_word           | one cycle per word, no back-pressure
//  config   | i_cfg_we, i_cfg_data       | threshold written when i_cfg_we
//
// one word enters per cycle, o_busy stays low
// the pipeline runs through 3 front stages, 31 square root steps,
// 30 vectoring cordic steps plus angle scaling, 30 rotation cordic steps,
// 23 divider steps and 3 blend stages
// synchronous reset clears all valid bits and loads the threshold default
// the result side never stalls, so the pipeline only moves forward
`default_nettype none

module quaternion_slerp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  qslp_pkg::t_in     i_word,
    output logic              o_strobe,
    output qslp_pkg::t_out    o_word,
    input  logic              i_cfg_we,
    input  qslp_pkg::t_frac   i_cfg_data
);
    import qslp_pkg::*;

    // linear threshold register
    t_frac r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    assign o_busy = 1'b0;

    // front end
    logic            fr_vld;
    t_side           fr_side;
    logic [2*CF:0]   fr_rest;
    logic [CF:0]     fr_d30;

    qslp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start & ~o_busy),
        .i_word  (i_word),
        .i_thr   (r_thr),
        .o_vld   (fr_vld),
        .o_side  (fr_side),
        .o_rest  (fr_rest),
        .o_d30   (fr_d30)
    );

    // square root of one minus dot squared
    logic        sq_vld;
    t_side       sq_side;
    logic [CF:0] sq_s30, sq_d30;

    qslp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .i_side  (fr_side),
        .i_rest  (fr_rest),
        .i_d30   (fr_d30),
        .o_vld   (sq_vld),
        .o_side  (sq_side),
        .o_s30   (sq_s30),
        .o_d30   (sq_d30)
    );

    // angle and scaled angles
    logic               ac_vld;
    t_side              ac_side;
    logic [2:0][AW-1:0] ac_ang;

    qslp_acos u_acos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .i_side  (sq_side),
        .i_d30   (sq_d30),
        .i_s30   (sq_s30),
        .o_vld   (ac_vld),
        .o_side  (ac_side),
        .o_ang   (ac_ang)
    );

    // sines
    logic               sn_vld;
    t_side              sn_side;
    logic [2:0][SW-1:0] sn_sin;

    qslp_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (ac_vld),
        .i_side  (ac_side),
        .i_ang   (ac_ang),
        .o_vld   (sn_vld),
        .o_side  (sn_side),
        .o_sin   (sn_sin)
    );

    // weights
    logic             dv_vld;
    t_side            dv_side;
    logic [1:0][FB:0] dv_wt;

    qslp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sn_vld),
        .i_side  (sn_side),
        .i_part  ({sn_sin[2], sn_sin[1]}),
        .i_whole (sn_sin[0]),
        .o_vld   (dv_vld),
        .o_side  (dv_side),
        .o_wt    (dv_wt)
    );

    // blend and output register
    qslp_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dv_vld),
        .i_side  (dv_side),
        .i_wa    (dv_wt[0]),
        .i_wb    (dv_wt[1]),
        .o_vld   (o_strobe),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

FILE: rtl/core/qslp_checker.sv
// port-level checks of the quaternion slerp pipeline, bound to the top level
// depends on qslp_pkg and quaternion_slerp_macros.svh
`default_nettype none

`include "quaternion_slerp_macros.svh"

module qslp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_start,
    input logic            o_busy,
    input qslp_pkg::t_in   i_word,
    input logic            o_strobe,
    input qslp_pkg::t_out  o_word
);
    import qslp_pkg::*;

    // nothing comes out right after reset
    `QSLP_ASSERT_NEXT(a_rst_quiet, !i_rst_n, !o_strobe, "strobe right after reset")

    // every result traces back to a word taken one latency earlier
    `QSLP_ASSERT_IMPL(a_strobe_src, o_strobe, $past(i_start && !o_busy, LAT), "strobe without a word")

    // the pipeline never holds the input side off
    `QSLP_ASSERT_IMPL(a_no_busy, i_start, !o_busy, "busy raised")

    // an accepted word carries known bits
    `QSLP_ASSERT_IMPL(a_in_known, i_start && !o_busy, !$isunknown(i_word), "unknown input word")

    // a result word carries known bits
    `QSLP_ASSERT_IMPL(a_out_known, o_strobe, !$isunknown(o_word), "unknown result word")

endmodule

bind quaternion_slerp qslp_checker u_qslp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_word   (i_word),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

`default_nettype wire

FILE: dv/quaternion_slerp_tb.sv
// testbench for the quaternion slerp pipeline: directed and random quaternion pairs
// depends on qslp_pkg and the quaternion_slerp rtl
`timescale 1ns / 1ps

module quaternion_slerp_tb;
    import qslp_pkg::*;

    localparam int WAIT_LIMIT = 2_000_000;
    localparam longint ONE_Q = 64'sd1 <<< 22;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    t_in i_word;
    logic o_strobe;
    t_out o_word;
    logic i_cfg_we;
    t_frac i_cfg_data;

    t_out expected_q[$];
    t_frac threshold;
    int errors;
    int cycles;

    quaternion_slerp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_word(i_word), .o_strobe(o_strobe), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // floor division by a power of two
    function automatic longint fl_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_of(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < NSTEP; i++) begin
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, dx, dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < NSTEP; i++) begin
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        return (y < 0) ? 0 : y;
    endfunction

    function automatic longint ratio_weight(longint part, longint whole);
        longint w;
        w = (part <<< 22) / whole;
        return (w > ONE_Q) ? ONE_Q : w;
    endfunction

    // expected interpolation of one word
    function automatic t_out slerp_of(t_in w);
        longint qa[4], qb[4];
        longint hsum, lsum, p, h, dot, t, wa, wb, d30, s30, ang, sin_all, acc, r;
        longint unsigned rest;
        logic lin;
        t_out res;
        qa = '{longint'(w.first_w), longint'(w.first_x),
               longint'(w.first_y), longint'(w.first_z)};
        qb = '{longint'(w.second_w), longint'(w.second_x),
               longint'(w.second_y), longint'(w.second_z)};
        hsum = 0;
        lsum = 0;
        for (int i = 0; i < 4; i++) begin
            p = qa[i] * qb[i];
            h = fl_shr(p, 22);
            hsum += h;
            lsum += p - h * ONE_Q;
        end
        dot = hsum + fl_shr(lsum, 22);
        t = longint'({1'b0, w.fraction});
        if (t > ONE_Q) t = ONE_Q;
        if (dot < 0) begin
            dot = -dot;
            for (int i = 0; i < 4; i++) qb[i] = -qb[i];
        end
        lin = dot >= longint'({1'b0, threshold});
        wa = ONE_Q - t;
        wb = t;
        if (!lin) begin
            d30 = ((dot > ONE_Q) ? ONE_Q : dot) <<< 8;
            rest = (64'd1 << 60) - longint'(d30 * d30);
            s30 = root_of(rest);
            ang = vector_angle(d30, s30);
            if (ang < 0) ang = 0;
            sin_all = rotate_sine(ang);
            if (sin_all <= 0) begin
                lin = 1;
            end else begin
                wa = ratio_weight(rotate_sine(fl_shr(ang * (ONE_Q - t), 22)), sin_all);
                wb = ratio_weight(rotate_sine(fl_shr(ang * t, 22)), sin_all);
            end
        end
        for (int i = 0; i < 4; i++) begin
            acc = qa[i] * wa + qb[i] * wb + (64'sd1 <<< 21);
            r = fl_shr(acc, 22);
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            case (i)
                0: res.out_w = t_comp'(r);
                1: res.out_x = t_comp'(r);
                2: res.out_y = t_comp'(r);
                default: res.out_z = t_comp'(r);
            endcase
        end
        res.used_linear = lin;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp_w = expected_q.pop_front();
                if (o_word.out_w !== exp_w.out_w) begin
                    $error("out_w exp %0d got %0d", exp_w.out_w, o_word.out_w); errors++;
                end
                if (o_word.out_x !== exp_w.out_x) begin
                    $error("out_x exp %0d got %0d", exp_w.out_x, o_word.out_x); errors++;
                end
                if (o_word.out_y !== exp_w.out_y) begin
                    $error("out_y exp %0d got %0d", exp_w.out_y, o_word.out_y); errors++;
                end
                if (o_word.out_z !== exp_w.out_z) begin
                    $error("out_z exp %0d got %0d", exp_w.out_z, o_word.out_z); errors++;
                end
                if (o_word.used_linear !== exp_w.used_linear) begin
                    $error("used_linear exp %0d got %0d", exp_w.used_linear,
                           o_word.used_linear);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > WAIT_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    int burst_left;

    // send one word, with bursty gaps before it
    task automatic send_word(t_in w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_start <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_q.push_back(slerp_of(w));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_frac v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
    endtask

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return t_comp'($urandom_range(0, 1) ? 4194304 : -4194304);
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_frac rand_frac();
        case ($urandom_range(0, 7))
            0: return 23'd0;
            1: return 23'd4194304;
            2: return t_frac'($urandom);
            default: return t_frac'($urandom_range(0, 4194304));
        endcase
    endfunction

    // quaternion pair whose second is the first with small offsets, negated at random
    function automatic t_in near_pair();
        t_in w;
        int s;
        w.first_w = t_comp'($urandom_range(0, 4194304));
        w.first_x = t_comp'($urandom_range(0, 2500000)) - 24'sd1250000;
        w.first_y = t_comp'($urandom_range(0, 2500000)) - 24'sd1250000;
        w.first_z = t_comp'($urandom_range(0, 2500000)) - 24'sd1250000;
        s = $urandom_range(0, 1) ? 1 : -1;
        w.second_w = t_comp'(s * (w.first_w + int'($urandom_range(0, 400)) - 200));
        w.second_x = t_comp'(s * (w.first_x + int'($urandom_range(0, 2000)) - 1000));
        w.second_y = t_comp'(s * (w.first_y + int'($urandom_range(0, 60000)) - 30000));
        w.second_z = t_comp'(s * w.first_z);
        w.fraction = rand_frac();
        return w;
    endfunction

    task automatic test_directed();
        t_in w;
        w = '{24'sh400000, 0, 0, 0, 24'sh400000, 0, 0, 0, 23'd2097152};
        send_word(w);
        w.second_w = 24'shC00000;
        send_word(w);
        w = '{24'sh400000, 0, 0, 0, 0, 24'sh400000, 0, 0, 23'd1048576};
        send_word(w);
        w.fraction = 23'h7FFFFF;
        send_word(w);
        w.fraction = 23'd0;
        send_word(w);
        w = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'd4194304};
        send_word(w);
        w = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
              24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF};
        send_word(w);
        w = '{24'sh2D413C, 24'sh2D413C, 0, 0, 24'sh400000, 0, 0, 0, 23'd2097152};
        send_word(w);
        w = '{0, 0, 0, 0, 0, 0, 0, 0, 23'd100};
        send_word(w);
        repeat (8) send_word(near_pair());
        drain();
    endtask

    task automatic test_random(int n);
        t_in w;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                w.first_w = rand_comp(); w.first_x = rand_comp();
                w.first_y = rand_comp(); w.first_z = rand_comp();
                w.second_w = rand_comp(); w.second_x = rand_comp();
                w.second_y = rand_comp(); w.second_z = rand_comp();
                w.fraction = rand_frac();
            end else begin
                w = near_pair();
            end
            send_word(w);
        end
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        threshold = THR_RESET;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150);
        write_threshold(23'd0);
        test_random(100);
        write_threshold(23'h7FFFFF);
        test_directed();
        test_random(150);
        write_threshold(23'd4194304);
        test_random(100);
        write_threshold(23'd4194000);
        test_random(150);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/qslp_pkg.sv
rtl/core/qslp_front.sv
rtl/core/qslp_isqrt.sv
rtl/core/qslp_acos.sv
rtl/core/qslp_sin.sv
rtl/core/qslp_div.sv
rtl/core/qslp_blend.sv
rtl/core/quaternion_slerp.sv
rtl/core/qslp_checker.sv
dv/quaternion_slerp_tb.sv
